// ===== src/cdps_pkg.sv =====
// Shared types, constants and delay tables for the clock delay parameter search.
package cdps_pkg;

	localparam int unsigned DELAY_W = 20;
	localparam int unsigned SEL_W = 3;
	localparam int unsigned FRAC_W = 6;
	localparam int unsigned STEP_W = 14;
	localparam int unsigned OFFSET_W = 17;
	localparam int unsigned TABLE_DEPTH = 32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} state_t;

	// One candidate setting presented to the compare unit.
	typedef struct packed {
		logic                 valid;
		logic                 first;
		logic [SEL_W-1:0]     ramp;
		logic [SEL_W-1:0]     mask;
		logic [FRAC_W-1:0]    frac;
		logic [DELAY_W-1:0]   delay;
		logic [DELAY_W-1:0]   target;
	} cand_t;

	// Fine step per fraction unit, Q0.16 ns held in 14 bits, indexed by {ramp, capacitor count}.
	localparam logic [STEP_W-1:0] STEP_TABLE [TABLE_DEPTH] = '{
		14'd4146, 14'd5528, 14'd6910, 14'd8292,
		14'd2073, 14'd2764, 14'd3455, 14'd4146,
		14'd1382, 14'd1843, 14'd2303, 14'd2764,
		14'd1037, 14'd1382, 14'd1728, 14'd2073,
		14'd829,  14'd1106, 14'd1382, 14'd1658,
		14'd691,  14'd921,  14'd1152, 14'd1382,
		14'd592,  14'd790,  14'd987,  14'd1185,
		14'd518,  14'd691,  14'd864,  14'd1037
	};

	// Base offset, Q1.16 ns, indexed by {ramp, capacitor count}.
	localparam logic [OFFSET_W-1:0] OFFSET_TABLE [TABLE_DEPTH] = '{
		17'd112067, 17'd114033, 17'd115999, 17'd117965,
		17'd99942,  17'd100925, 17'd101908, 17'd102892,
		17'd87163,  17'd87818,  17'd88474,  17'd89129,
		17'd74220,  17'd74711,  17'd75203,  17'd75694,
		17'd61211,  17'd61604,  17'd61997,  17'd62390,
		17'd48169,  17'd48497,  17'd48824,  17'd49152,
		17'd35109,  17'd35389,  17'd35670,  17'd35951,
		17'd22036,  17'd22282,  17'd22528,  17'd22774
	};

	function automatic logic [1:0] cap_count(input logic [SEL_W-1:0] mask);
		cap_count = {1'b0, mask[0]} + {1'b0, mask[1]} + {1'b0, mask[2]};
	endfunction

	function automatic logic [STEP_W-1:0] step_lookup(input logic [SEL_W-1:0] ramp,
			input logic [SEL_W-1:0] mask);
		step_lookup = STEP_TABLE[{ramp, cap_count(mask)}];
	endfunction

	function automatic logic [OFFSET_W-1:0] offset_lookup(input logic [SEL_W-1:0] ramp,
			input logic [SEL_W-1:0] mask);
		offset_lookup = OFFSET_TABLE[{ramp, cap_count(mask)}];
	endfunction

endpackage

// ===== src/clock_delay_parameter_search.sv =====
// Top level of the clock delay parameter search.
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  delay_target
//  out      output     out_valid/out_stall ramp_select, cap_select, fraction,
//                                          achieved_delay, abs_error
//
// One request visits 8 * 8 * (FRACTION_MAX + 1) candidates (3072 by default),
// one per cycle through the single error compare unit; the request is taken
// in the idle state and the result is held until out_stall is low.
// The delay accumulator adds one fine step per candidate, reloading the
// offset when the ramp or mask setting moves on.
// Reset clears the sequencer state and counters; the delay, target and result registers are loaded by the search.
// The next request is taken only after the result transfer completes.
module clock_delay_parameter_search #(
	parameter int unsigned FRACTION_MAX = 47
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cdps_pkg::DELAY_W-1:0]  delay_target,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cdps_pkg::SEL_W-1:0]    ramp_select,
	output logic [cdps_pkg::SEL_W-1:0]    cap_select,
	output logic [cdps_pkg::FRAC_W-1:0]   fraction,
	output logic [cdps_pkg::DELAY_W-1:0]  achieved_delay,
	output logic [cdps_pkg::DELAY_W-1:0]  abs_error
);
	import cdps_pkg::*;

	cand_t cand;

	cdps_seq #(
		.FRACTION_MAX(FRACTION_MAX)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.delay_target (delay_target),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cand         (cand)
	);

	cdps_best u_best (
		.clk            (clk),
		.arst_n         (arst_n),
		.cand           (cand),
		.ramp_select    (ramp_select),
		.cap_select     (cap_select),
		.fraction       (fraction),
		.achieved_delay (achieved_delay),
		.abs_error      (abs_error)
	);

endmodule

// ===== src/cdps_seq.sv =====
// Sequencer: walks ramp, mask and fraction and accumulates the candidate delay.
module cdps_seq #(
	parameter int unsigned FRACTION_MAX = 47
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cdps_pkg::DELAY_W-1:0]  delay_target,
	output logic                          out_valid,
	input  logic                          out_stall,
	output cdps_pkg::cand_t               cand
);
	import cdps_pkg::*;

	localparam logic [FRAC_W-1:0] FRAC_LAST = FRAC_W'(FRACTION_MAX);
	localparam logic [SEL_W-1:0] SEL_LAST = {SEL_W{1'b1}};

	state_t state_q, state_nx;
	logic [SEL_W-1:0] ramp_q, mask_q, ramp_nx, mask_nx;
	logic [FRAC_W-1:0] frac_q;
	logic [DELAY_W-1:0] delay_q, target_q;
	logic in_xfer, frac_wrap, last_cand;

	assign in_xfer = in_valid && !in_stall;
	assign frac_wrap = (frac_q == FRAC_LAST);
	assign last_cand = frac_wrap && (mask_q == SEL_LAST) && (ramp_q == SEL_LAST);
	assign mask_nx = mask_q + SEL_W'(1);
	assign ramp_nx = (mask_q == SEL_LAST) ? ramp_q + SEL_W'(1) : ramp_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (last_cand) state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (!out_stall) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_DONE);
		cand.valid = (state_q == ST_SEARCH);
		cand.first = (ramp_q == '0) && (mask_q == '0) && (frac_q == '0);
		cand.ramp = ramp_q;
		cand.mask = mask_q;
		cand.frac = frac_q;
		cand.delay = delay_q;
		cand.target = target_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ramp_q <= '0;
			mask_q <= '0;
			frac_q <= '0;
		end else begin
			state_q <= state_nx;
			if (in_xfer) begin
				ramp_q <= '0;
				mask_q <= '0;
				frac_q <= '0;
			end else if (state_q == ST_SEARCH) begin
				if (frac_wrap) begin
					frac_q <= '0;
					mask_q <= mask_nx;
					ramp_q <= ramp_nx;
				end else begin
					frac_q <= frac_q + FRAC_W'(1);
				end
			end
		end
	end

	// Reload the offset at each new setting, otherwise add one fine step.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			target_q <= delay_target;
			delay_q <= DELAY_W'(offset_lookup('0, '0));
		end else if (state_q == ST_SEARCH) begin
			if (frac_wrap) begin
				delay_q <= DELAY_W'(offset_lookup(ramp_nx, mask_nx));
			end else begin
				delay_q <= delay_q + DELAY_W'(step_lookup(ramp_q, mask_q));
			end
		end
	end

`ifndef SYNTHESIS
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		cand.valid |-> (cand.frac <= FRAC_LAST))
		else $error("fraction counter beyond its last value");
	a_start_first: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (cand.valid && cand.first))
		else $error("search did not start at the first candidate");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cand.valid && last_cand) |=> out_valid)
		else $error("no result after the last candidate");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && cand.valid))
		else $error("result offered while still searching");
`endif

endmodule

// ===== src/cdps_best.sv =====
// Shared compare unit: error of each candidate and the running best setting.
module cdps_best (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cdps_pkg::cand_t               cand,
	output logic [cdps_pkg::SEL_W-1:0]    ramp_select,
	output logic [cdps_pkg::SEL_W-1:0]    cap_select,
	output logic [cdps_pkg::FRAC_W-1:0]   fraction,
	output logic [cdps_pkg::DELAY_W-1:0]  achieved_delay,
	output logic [cdps_pkg::DELAY_W-1:0]  abs_error
);
	import cdps_pkg::*;

	logic [SEL_W-1:0] ramp_q, mask_q;
	logic [FRAC_W-1:0] frac_q;
	logic [DELAY_W-1:0] delay_q, err_q, err;
	logic take;

	assign err = (cand.delay > cand.target) ? cand.delay - cand.target
		: cand.target - cand.delay;
	// Keep the earlier candidate on a tie.
	assign take = cand.valid && (cand.first || (err < err_q));

	always_ff @(posedge clk) begin
		if (take) begin
			ramp_q <= cand.ramp;
			mask_q <= cand.mask;
			frac_q <= cand.frac;
			delay_q <= cand.delay;
			err_q <= err;
		end
	end

	assign ramp_select = ramp_q;
	assign cap_select = mask_q;
	assign fraction = frac_q;
	assign achieved_delay = delay_q;
	assign abs_error = err_q;

`ifndef SYNTHESIS
	a_first_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(cand.valid && cand.first) |=> (ramp_q == '0 && mask_q == '0 && frac_q == '0))
		else $error("first candidate not taken");
	a_err_match: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cand.valid) |-> (err_q == ((delay_q > cand.target) ? delay_q - cand.target
			: cand.target - delay_q)))
		else $error("stored error does not match stored delay");
	a_err_falls: assert property (@(posedge clk) disable iff (!arst_n)
		($past(cand.valid) && !$past(cand.first)) |-> (err_q <= $past(err_q)))
		else $error("best error grew during the search");
`endif

endmodule
